[rtl/core/tsf_pkg.sv]
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared types, constants and helpers for the two-class shared queue.
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int DEPTH      = 16;
  localparam int ID_BITS    = 16;
  localparam int PORT_ID_W  = 16;

  typedef enum logic [1:0] {
    OP_ENQ       = 2'd0,
    OP_DEQ_ANY   = 2'd1,
    OP_DEQ_CLASS = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic                 valid;
    logic [1:0]           op;
    logic                 cls;
    logic [ID_BITS-1:0]   id;
  } cmd_t;

  // Contents of one cell
  typedef struct packed {
    logic                 used;
    logic                 cls;
    logic [ID_BITS-1:0]   id;
  } slot_t;

  // Search chain: match seen so far and the data of the matching cell
  typedef struct packed {
    logic                 found;
    logic                 cls;
    logic [ID_BITS-1:0]   id;
  } link_t;

  function automatic logic [ID_BITS-1:0] id_from_port(input logic [PORT_ID_W-1:0] x);
    logic [ID_BITS-1:0] r;
    r = '0;
    for (int b = 0; b < ID_BITS; b++) begin
      r[b] = (b < PORT_ID_W) ? x[b] : 1'b0;
    end
    return r;
  endfunction

  function automatic logic [PORT_ID_W-1:0] id_to_port(input logic [ID_BITS-1:0] x);
    logic [PORT_ID_W-1:0] r;
    r = '0;
    for (int b = 0; b < PORT_ID_W; b++) begin
      r[b] = (b < ID_BITS) ? x[b] : 1'b0;
    end
    return r;
  endfunction

endpackage

[rtl/core/tsf_cell.sv]
// ----------------------------------------------------------------------------
// tsf_cell
// One queue slot: takes an enqueue, joins the oldest-match search and
// shifts toward the front when an older or its own entry leaves.
// ----------------------------------------------------------------------------
module tsf_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  tsf_pkg::cmd_t  cmd,
  input  logic           left_used,
  input  tsf_pkg::slot_t right_slot,
  input  tsf_pkg::link_t link_in,
  output tsf_pkg::link_t link_out,
  output tsf_pkg::slot_t slot
);

  logic                         used_r, used_nxt;
  logic                         cls_r, cls_nxt;
  logic [tsf_pkg::ID_BITS-1:0]  id_r, id_nxt;
  logic                         is_deq, match, hit, shift, wr;

  always_comb begin
    is_deq = 1'b0;
    match  = 1'b0;
    case (cmd.op)
      tsf_pkg::OP_DEQ_ANY: begin
        is_deq = 1'b1;
        match  = used_r;
      end
      tsf_pkg::OP_DEQ_CLASS: begin
        is_deq = 1'b1;
        match  = used_r && (cls_r == cmd.cls);
      end
      default: begin
        is_deq = 1'b0;
        match  = 1'b0;
      end
    endcase
  end

  assign hit   = cmd.valid && match && !link_in.found;
  // first free slot: occupied slots always form a prefix
  assign wr    = cmd.valid && (cmd.op == tsf_pkg::OP_ENQ) && !used_r && left_used;
  assign shift = cmd.valid && is_deq && (link_in.found || hit);

  always_comb begin
    link_out.found = link_in.found || hit;
    link_out.cls   = hit ? cls_r : link_in.cls;
    link_out.id    = hit ? id_r  : link_in.id;
  end

  always_comb begin
    used_nxt = used_r;
    cls_nxt  = cls_r;
    id_nxt   = id_r;
    if (shift) begin
      used_nxt = right_slot.used;
      cls_nxt  = right_slot.cls;
      id_nxt   = right_slot.id;
    end else if (wr) begin
      used_nxt = 1'b1;
      cls_nxt  = cmd.cls;
      id_nxt   = cmd.id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cls_r <= cls_nxt;
    id_r  <= id_nxt;
  end

  assign slot.used = used_r;
  assign slot.cls  = cls_r;
  assign slot.id   = id_r;

endmodule

[rtl/core/two_class_shared_fifo_unit.sv]
// ----------------------------------------------------------------------------
// two_class_shared_fifo_unit
// Arrival-ordered queue of cat/dog entries built as a chain of slot cells.
// ----------------------------------------------------------------------------
// The result strobes on out_valid in the cycle after start is taken.
// Throughput: one operation per cycle; the oldest-match search and the
// gap-closing shift both complete in one pass along the cell chain.
// busy stays low, so start may be held high every cycle.
// Reset empties the queue at once (slot used bits clear); no clearing pass.
// ----------------------------------------------------------------------------
module two_class_shared_fifo_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic        in_pet_class,
  input  logic [15:0] in_pet_id,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_class,
  output logic [15:0] out_id
);

  tsf_pkg::cmd_t   cmd;
  tsf_pkg::slot_t  slots [tsf_pkg::DEPTH];
  tsf_pkg::link_t  links [tsf_pkg::DEPTH+1];
  logic [tsf_pkg::DEPTH-1:0] used_vec;

  logic         valid_r, valid_nxt;
  logic [1:0]   status_r, status_nxt;
  logic         cls_r, cls_nxt;
  logic [15:0]  id_r, id_nxt;

  assign busy = 1'b0;

  always_comb begin
    cmd.valid = start && !busy;
    cmd.op    = in_op;
    cmd.cls   = in_pet_class;
    cmd.id    = tsf_pkg::id_from_port(in_pet_id);
  end

  assign links[0] = '0;

  for (genvar i = 0; i < tsf_pkg::DEPTH; i++) begin : g_cell
    logic           left_used;
    tsf_pkg::slot_t right_slot;

    if (i == 0) begin : g_head
      assign left_used = 1'b1;
    end else begin : g_body
      assign left_used = slots[i-1].used;
    end

    if (i == tsf_pkg::DEPTH-1) begin : g_tail
      assign right_slot = '0;
    end else begin : g_mid
      assign right_slot = slots[i+1];
    end

    tsf_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_used  (left_used),
      .right_slot (right_slot),
      .link_in    (links[i]),
      .link_out   (links[i+1]),
      .slot       (slots[i])
    );

    assign used_vec[i] = slots[i].used;
  end

  always_comb begin
    valid_nxt  = cmd.valid;
    status_nxt = tsf_pkg::ST_NONE;
    cls_nxt    = 1'b0;
    id_nxt     = '0;
    case (in_op) inside
      tsf_pkg::OP_ENQ: begin
        status_nxt = used_vec[tsf_pkg::DEPTH-1] ? tsf_pkg::ST_FULL : tsf_pkg::ST_DONE;
      end
      tsf_pkg::OP_DEQ_ANY, tsf_pkg::OP_DEQ_CLASS: begin
        if (links[tsf_pkg::DEPTH].found) begin
          status_nxt = tsf_pkg::ST_DONE;
          cls_nxt    = links[tsf_pkg::DEPTH].cls;
          id_nxt     = tsf_pkg::id_to_port(links[tsf_pkg::DEPTH].id);
        end
      end
      default: begin
        status_nxt = tsf_pkg::ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    cls_r    <= cls_nxt;
    id_r     <= id_nxt;
  end

  assign out_valid  = valid_r;
  assign out_status = status_r;
  assign out_class  = cls_r;
  assign out_id     = id_r;

  // occupied slots must stay a prefix of the chain
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((used_vec >> 1) & ~used_vec) == '0)
    else $error("queue occupancy is not a prefix");

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> out_valid)
    else $error("missing result strobe");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !start |=> !out_valid)
    else $error("result strobe without a command");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != tsf_pkg::ST_DONE) |-> (out_id == '0 && out_class == 1'b0))
    else $error("payload not zero on failed operation");

  a_full_enq: assert property (@(posedge clk) disable iff (!rst_n)
    (start && in_op == tsf_pkg::OP_ENQ && used_vec[tsf_pkg::DEPTH-1]) |=>
      (out_status == tsf_pkg::ST_FULL && $stable(used_vec)))
    else $error("enqueue into full queue changed state");

endmodule
